// ----- hdl/wmtd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wmtd_pkg: shared constants and types for the weighted multi-tap delay
// Store geometry, tap count, command codes, register map and mix limits.
// ----------------------------------------------------------------------------
package wmtd_pkg;

	localparam int STORE_DEPTH = 1024;  // samples in the circular store, 2..65536
	localparam int NUM_TAPS    = 4;     // active taps, 1..4
	localparam int TAP_SLOTS   = 4;     // tap output ports

	localparam int ADDR_W    = $clog2(STORE_DEPTH);
	localparam int TAP_IDX_W = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
	localparam int CNT_W     = $clog2(NUM_TAPS + 2);
	localparam int ACC_W     = 32 + $clog2(NUM_TAPS);

	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 16;
	localparam int DLY_W     = 11;
	localparam int CMD_W     = 2;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 16;

	localparam int RND_BIAS  = 2048;    // half an LSB of Q1.15 in Q5.27
	localparam int RND_SHIFT = 12;
	localparam int SAT_MAX   = 32767;
	localparam int SAT_MIN   = -32768;

	typedef enum logic [CMD_W-1:0] {
		CMD_PROCESS = 2'd0,
		CMD_READ    = 2'd1,
		CMD_WRITE   = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	localparam logic [REG_IDX_W-1:0] REG_DELAY_TAP0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_TAP0  = 3'd4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage
`default_nettype wire

// ----- hdl/weighted_multi_tap_delay.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_multi_tap_delay: circular sample store with weighted tap mixing
// Four read taps trail one write position; one shared multiplier mixes them.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries cmd and sample_in. Process
//    reads all taps, returns the rounded, saturated weighted sum and stores
//    the sample. Read returns the raw taps only and advances the taps. Write
//    stores the sample with no result. The unused code is dropped.
//  - Output channel (out_valid/out_ready) carries mixed_out and tap_value0..3.
//  - Write stores in the accept cycle; in_ready stays high, so writes and
//    dropped codes can follow back to back.
//  - Process and read keep in_ready low from the accept until the final
//    step, so the next item is taken only after it: the store's single
//    read port reads one tap per cycle into the shared multiply-accumulate,
//    the multiply and add registers then drain, and the final step rounds
//    and stores.
//  - The result is registered; in_ready returns while it waits. If the
//    receiver stalls, the next process or read item holds in its final
//    cycle until the output register is free.
//  - After reset the store is cleared one entry per cycle, through all
//    STORE_DEPTH entries, with in_ready low. Configuration writes are taken then.
//  - Configuration: cfg_we/cfg_index/cfg_wdata, index 0..3 delays (moves the
//    tap relative to the write position), 4..7 gains Q4.12. Write when idle.
// ----------------------------------------------------------------------------
module weighted_multi_tap_delay (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [wmtd_pkg::REG_IDX_W-1:0]        cfg_index,
	input  wire logic [wmtd_pkg::CFG_W-1:0]            cfg_wdata,
	input  wire logic                                  in_valid,
	output      logic                                  in_ready,
	input  wire logic [wmtd_pkg::CMD_W-1:0]            cmd,
	input  wire logic signed [wmtd_pkg::SAMPLE_W-1:0]  sample_in,
	output      logic                                  out_valid,
	input  wire logic                                  out_ready,
	output      logic signed [wmtd_pkg::SAMPLE_W-1:0]  mixed_out,
	output      logic signed [wmtd_pkg::SAMPLE_W-1:0]  tap_value0,
	output      logic signed [wmtd_pkg::SAMPLE_W-1:0]  tap_value1,
	output      logic signed [wmtd_pkg::SAMPLE_W-1:0]  tap_value2,
	output      logic signed [wmtd_pkg::SAMPLE_W-1:0]  tap_value3
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	// advance a store position, wrapping at the store depth
	function automatic logic [wmtd_pkg::ADDR_W-1:0] next_pos(
		input logic [wmtd_pkg::ADDR_W-1:0] p
	);
		if (p == wmtd_pkg::ADDR_W'(wmtd_pkg::STORE_DEPTH - 1)) begin
			return '0;
		end
		return p + wmtd_pkg::ADDR_W'(1);
	endfunction

	// place a tap d samples behind the write position; zero or full depth
	// lands on the write position
	function automatic logic [wmtd_pkg::ADDR_W-1:0] place_pos(
		input logic [wmtd_pkg::ADDR_W-1:0] wp,
		input logic [wmtd_pkg::DLY_W-1:0]  d
	);
		logic [31:0] w32;
		logic [31:0] d32;
		w32 = 32'(wp);
		d32 = 32'(d);
		if (d32 == 32'd0 || d32 == 32'(wmtd_pkg::STORE_DEPTH)) begin
			return wp;
		end
		if (w32 >= d32) begin
			return wmtd_pkg::ADDR_W'(w32 - d32);
		end
		return wmtd_pkg::ADDR_W'(w32 + 32'(wmtd_pkg::STORE_DEPTH) - d32);
	endfunction

	function automatic logic [wmtd_pkg::ADDR_W-1:0] reset_pos(input int t);
		return wmtd_pkg::ADDR_W'((wmtd_pkg::STORE_DEPTH
			- ((t + 1) % wmtd_pkg::STORE_DEPTH)) % wmtd_pkg::STORE_DEPTH);
	endfunction

	state_t                                   state_q;
	logic [wmtd_pkg::ADDR_W-1:0]              clr_q;
	logic [wmtd_pkg::ADDR_W-1:0]              wp_q;
	logic [wmtd_pkg::ADDR_W-1:0]              pos_q [wmtd_pkg::NUM_TAPS];
	logic signed [wmtd_pkg::GAIN_W-1:0]       gain_q [wmtd_pkg::NUM_TAPS];
	logic [wmtd_pkg::CNT_W-1:0]               cnt_q;
	wmtd_pkg::cmd_t                           cmd_q;
	wmtd_pkg::sample_t                        sample_q;
	wmtd_pkg::sample_t                        tap_q [wmtd_pkg::NUM_TAPS];
	logic signed [wmtd_pkg::ACC_W-1:0]        acc_q;
	logic                                     out_valid_q;
	wmtd_pkg::sample_t                        mixed_q;
	wmtd_pkg::sample_t                        tap_out_q [wmtd_pkg::TAP_SLOTS];

	logic                                     vld_s1;
	logic [wmtd_pkg::TAP_IDX_W-1:0]           idx_s1;
	wmtd_pkg::sample_t                        rd_data_s1;
	logic                                     vld_s2;
	logic signed [31:0]                       prod_s2;

	wmtd_pkg::sample_t                        store_q [wmtd_pkg::STORE_DEPTH];

	logic                                     in_fire;
	logic                                     out_free;
	logic                                     issue;
	logic [wmtd_pkg::TAP_IDX_W-1:0]           issue_idx;
	logic                                     mem_we;
	logic [wmtd_pkg::ADDR_W-1:0]              mem_waddr;
	wmtd_pkg::sample_t                        mem_wdata;
	logic [wmtd_pkg::ADDR_W-1:0]              mem_raddr;
	logic signed [wmtd_pkg::ACC_W:0]          rnd;
	logic signed [wmtd_pkg::ACC_W:0]          rnd_q15;
	wmtd_pkg::sample_t                        mixed_sat;
	wmtd_pkg::sample_t                        tap_slot [wmtd_pkg::TAP_SLOTS];
	logic [1:0]                               cfg_tap;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign issue     = (state_q == ST_RUN) && (cnt_q < wmtd_pkg::CNT_W'(wmtd_pkg::NUM_TAPS));
	assign issue_idx = cnt_q[wmtd_pkg::TAP_IDX_W-1:0];
	assign mem_raddr = pos_q[issue_idx];
	assign cfg_tap   = cfg_index[1:0];

	// one write port shared by the clear sweep, write items and process items
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wp_q;
		mem_wdata = sample_in;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (in_fire && cmd == wmtd_pkg::CMD_WRITE) begin
			mem_we = 1'b1;
		end else if (state_q == ST_FIN && cmd_q == wmtd_pkg::CMD_PROCESS && out_free) begin
			mem_we    = 1'b1;
			mem_wdata = sample_q;
		end
	end

	// round half up to Q1.15, then clamp
	always_comb begin
		rnd     = (wmtd_pkg::ACC_W + 1)'(acc_q) + (wmtd_pkg::ACC_W + 1)'(wmtd_pkg::RND_BIAS);
		rnd_q15 = rnd >>> wmtd_pkg::RND_SHIFT;
		if (rnd_q15 > wmtd_pkg::SAT_MAX) begin
			mixed_sat = wmtd_pkg::SAMPLE_W'(wmtd_pkg::SAT_MAX);
		end else if (rnd_q15 < wmtd_pkg::SAT_MIN) begin
			mixed_sat = wmtd_pkg::SAMPLE_W'(wmtd_pkg::SAT_MIN);
		end else begin
			mixed_sat = rnd_q15[wmtd_pkg::SAMPLE_W-1:0];
		end
	end

	// tap ports beyond the active taps read zero
	always_comb begin
		for (int s = 0; s < wmtd_pkg::TAP_SLOTS; s++) begin
			tap_slot[s] = '0;
		end
		for (int s = 0; s < wmtd_pkg::NUM_TAPS; s++) begin
			tap_slot[s] = tap_q[s];
		end
	end

	// sample store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= store_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			wp_q        <= '0;
			cnt_q       <= '0;
			cmd_q       <= wmtd_pkg::CMD_PROCESS;
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			vld_s2      <= 1'b0;
			acc_q       <= '0;
			for (int t = 0; t < wmtd_pkg::NUM_TAPS; t++) begin
				pos_q[t]  <= reset_pos(t);
				gain_q[t] <= '0;
			end
		end else begin
			// configuration: delays move the tap, gains are held
			if (cfg_we) begin
				if (cfg_index < wmtd_pkg::REG_GAIN_TAP0) begin
					if (32'(cfg_tap) < 32'(wmtd_pkg::NUM_TAPS)
						&& 32'(cfg_wdata[wmtd_pkg::DLY_W-1:0]) <= 32'(wmtd_pkg::STORE_DEPTH)) begin
						pos_q[cfg_tap[wmtd_pkg::TAP_IDX_W-1:0]] <=
							place_pos(wp_q, cfg_wdata[wmtd_pkg::DLY_W-1:0]);
					end
				end else if (32'(cfg_tap) < 32'(wmtd_pkg::NUM_TAPS)) begin
					gain_q[cfg_tap[wmtd_pkg::TAP_IDX_W-1:0]] <= cfg_wdata;
				end
			end

			// tap pipeline: issue read, multiply, accumulate
			vld_s1 <= issue;
			idx_s1 <= issue_idx;
			if (issue) begin
				pos_q[issue_idx] <= next_pos(pos_q[issue_idx]);
			end
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				tap_q[idx_s1] <= rd_data_s1;
				prod_s2       <= rd_data_s1 * gain_q[idx_s1];
			end
			if (vld_s2) begin
				acc_q <= acc_q + wmtd_pkg::ACC_W'(prod_s2);
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= next_pos(clr_q);
					if (clr_q == wmtd_pkg::ADDR_W'(wmtd_pkg::STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						case (wmtd_pkg::cmd_t'(cmd))
							wmtd_pkg::CMD_PROCESS, wmtd_pkg::CMD_READ: begin
								cmd_q    <= wmtd_pkg::cmd_t'(cmd);
								sample_q <= sample_in;
								cnt_q    <= '0;
								acc_q    <= '0;
								state_q  <= ST_RUN;
							end
							wmtd_pkg::CMD_WRITE: begin
								wp_q <= next_pos(wp_q);
							end
							default: begin
								// drop the unused code
							end
						endcase
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + wmtd_pkg::CNT_W'(1);
					if (cnt_q == wmtd_pkg::CNT_W'(wmtd_pkg::NUM_TAPS + 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						mixed_q     <= (cmd_q == wmtd_pkg::CMD_PROCESS) ? mixed_sat : '0;
						for (int s = 0; s < wmtd_pkg::TAP_SLOTS; s++) begin
							tap_out_q[s] <= tap_slot[s];
						end
						if (cmd_q == wmtd_pkg::CMD_PROCESS) begin
							wp_q <= next_pos(wp_q);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign mixed_out  = mixed_q;
	assign tap_value0 = tap_out_q[0];
	assign tap_value1 = tap_out_q[1];
	assign tap_value2 = tap_out_q[2];
	assign tap_value3 = tap_out_q[3];

	// a result is only loaded from the final step
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside the final step");

	// the tap pipeline is drained before rounding and storing
	a_drained_at_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (!vld_s1 && !vld_s2))
		else $error("tap pipeline busy in the final step");

	// the write position moves only with a store write outside the clear sweep
	a_wp_moves_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q != $past(wp_q)) |-> $past(mem_we && state_q != ST_CLEAR))
		else $error("write position moved without a store write");

	// tap reads come only from the run step
	a_read_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q == ST_RUN))
		else $error("tap read issued outside the run step");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for weighted_multi_tap_delay
// Sends process, read, write and dropped commands through the input handshake.
// A shadow copy of the sample store, write pointer, tap pointers and registers
// predicts every mixed sum and raw tap read. Each returned item is compared
// field by field. Sender gaps, receiver stalls, a long output hold-off and
// register changes between phases are mixed in.
// ----------------------------------------------------------------------------
module tb_top;

	localparam real CLK_PERIOD     = 12.0;
	localparam int  RESET_CYCLES   = 11;
	localparam int  DRAIN_CYCLES   = 16;
	localparam int  HOLD_LEN       = 300;   // receiver hold-off, in cycles
	localparam int  MAX_GAP        = 20;
	// clearing pass over the whole store and the hold-off, several times over
	localparam int  WATCHDOG_LIMIT = 4 * (wmtd_pkg::STORE_DEPTH + HOLD_LEN + 100);
	localparam int  PHASE_ITEMS    = 232;
	localparam int  ITEMS_PER_CFG  = 58;

	typedef struct packed {
		wmtd_pkg::sample_t                         mixed;
		wmtd_pkg::sample_t [wmtd_pkg::TAP_SLOTS-1:0] taps;
	} mix_result_t;

	// DUT ports; the inputs are driven to known values from time zero
	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [wmtd_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [wmtd_pkg::CFG_W-1:0]     cfg_wdata = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic [wmtd_pkg::CMD_W-1:0]     cmd       = '0;
	wmtd_pkg::sample_t              sample_in = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	wmtd_pkg::sample_t              mixed_out;
	wmtd_pkg::sample_t              tap_value0;
	wmtd_pkg::sample_t              tap_value1;
	wmtd_pkg::sample_t              tap_value2;
	wmtd_pkg::sample_t              tap_value3;

	// shadow of the block's state
	wmtd_pkg::sample_t                  echo_mem [wmtd_pkg::STORE_DEPTH];
	int unsigned                        wr_ptr;
	int unsigned                        tap_rd   [wmtd_pkg::TAP_SLOTS];
	logic [wmtd_pkg::DLY_W-1:0]         tap_dly  [wmtd_pkg::TAP_SLOTS];
	logic signed [wmtd_pkg::GAIN_W-1:0] tap_gain [wmtd_pkg::TAP_SLOTS];

	// mixes still owed by the block, oldest first
	mix_result_t pending_mix [$];
	// register values to load on the next apply_config, by register index
	logic [wmtd_pkg::CFG_W-1:0] cfg_plan [2*wmtd_pkg::TAP_SLOTS];

	int unsigned mismatch_cnt = 0;
	int unsigned idle_pct     = 0;
	int unsigned stall_pct    = 0;
	bit          hold_on      = 1'b0;
	int unsigned hold_cnt     = 0;
	int unsigned quiet_cycles = 0;

	weighted_multi_tap_delay u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mixed_out  (mixed_out),
		.tap_value0 (tap_value0),
		.tap_value1 (tap_value1),
		.tap_value2 (tap_value2),
		.tap_value3 (tap_value3)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	// ------------------------------------------------------------------------
	// Shadow model
	// ------------------------------------------------------------------------

	// store index that trails the write pointer by dly samples; zero wraps to
	// the write pointer itself, i.e. a full-store delay
	function automatic int unsigned trail_pos(int unsigned dly);
		return (wr_ptr + wmtd_pkg::STORE_DEPTH - (dly % wmtd_pkg::STORE_DEPTH))
			% wmtd_pkg::STORE_DEPTH;
	endfunction

	task automatic shadow_reset();
		for (int i = 0; i < wmtd_pkg::STORE_DEPTH; i++) echo_mem[i] = '0;
		wr_ptr = 0;
		for (int t = 0; t < wmtd_pkg::TAP_SLOTS; t++) begin
			tap_dly[t]  = wmtd_pkg::DLY_W'(t + 1);
			tap_gain[t] = '0;
			tap_rd[t]   = trail_pos(t + 1);
		end
	endtask

	function automatic void shadow_reg_write(logic [wmtd_pkg::REG_IDX_W-1:0] idx,
			logic [wmtd_pkg::CFG_W-1:0] data);
		int t;
		if (idx < wmtd_pkg::REG_GAIN_TAP0) begin
			t = idx - wmtd_pkg::REG_DELAY_TAP0;
			tap_dly[t] = data[wmtd_pkg::DLY_W-1:0];
			// a delay past the store length is held but leaves the tap where it is
			if (t < wmtd_pkg::NUM_TAPS && tap_dly[t] <= wmtd_pkg::STORE_DEPTH)
				tap_rd[t] = trail_pos(tap_dly[t]);
		end else begin
			tap_gain[idx - wmtd_pkg::REG_GAIN_TAP0] = data[wmtd_pkg::GAIN_W-1:0];
		end
	endfunction

	// advance the shadow by one accepted item and queue the mix it owes
	function automatic void mix_predict(wmtd_pkg::cmd_t op, wmtd_pkg::sample_t smp);
		mix_result_t       r;
		wmtd_pkg::sample_t tv;
		longint            acc;
		longint            q;
		if (op == wmtd_pkg::CMD_NOP) return;
		if (op == wmtd_pkg::CMD_WRITE) begin
			echo_mem[wr_ptr] = smp;
			wr_ptr = (wr_ptr + 1) % wmtd_pkg::STORE_DEPTH;
			return;
		end
		r   = '0;
		acc = 0;
		// read every tap before the store is written
		for (int t = 0; t < wmtd_pkg::NUM_TAPS; t++) begin
			tv = echo_mem[tap_rd[t]];
			r.taps[t] = tv;
			tap_rd[t] = (tap_rd[t] + 1) % wmtd_pkg::STORE_DEPTH;
			acc += longint'(tv) * longint'(tap_gain[t]);
		end
		if (op == wmtd_pkg::CMD_PROCESS) begin
			// round half up: add half an output step, floor by the arithmetic shift
			q = (acc + wmtd_pkg::RND_BIAS) >>> wmtd_pkg::RND_SHIFT;
			if (q > wmtd_pkg::SAT_MAX) q = wmtd_pkg::SAT_MAX;
			else if (q < wmtd_pkg::SAT_MIN) q = wmtd_pkg::SAT_MIN;
			r.mixed = wmtd_pkg::sample_t'(q);
			echo_mem[wr_ptr] = smp;
			wr_ptr = (wr_ptr + 1) % wmtd_pkg::STORE_DEPTH;
		end
		pending_mix.insert(pending_mix.size(), r);
	endfunction

	// ------------------------------------------------------------------------
	// Result checker: compare each accepted item with the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		mix_result_t       want;
		wmtd_pkg::sample_t got [wmtd_pkg::TAP_SLOTS];
		if (out_valid && out_ready) begin
			got = '{tap_value0, tap_value1, tap_value2, tap_value3};
			if (pending_mix.size() == 0) begin
				$error("unexpected item: mixed_out %0d with nothing pending", mixed_out);
				mismatch_cnt++;
			end else begin
				want = pending_mix.pop_front();
				if (mixed_out !== want.mixed) begin
					$error("mixed_out: expected %0d, got %0d", $signed(want.mixed),
						mixed_out);
					mismatch_cnt++;
				end
				for (int t = 0; t < wmtd_pkg::TAP_SLOTS; t++) begin
					if (got[t] !== want.taps[t]) begin
						$error("tap_value%0d: expected %0d, got %0d", t,
							$signed(want.taps[t]), got[t]);
						mismatch_cnt++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus a hold-off counted here once requested
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!hold_on)
			hold_cnt <= 0;
		else if (hold_cnt < HOLD_LEN)
			hold_cnt <= hold_cnt + 1;
		if (hold_on && hold_cnt < HOLD_LEN)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run if no handshake completes for too long
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// offer one item after a random gap; hold valid and payload until taken
	task automatic send_item(wmtd_pkg::cmd_t op, wmtd_pkg::sample_t smp);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= op;
		sample_in <= smp;
		do @(posedge clk); while (!in_ready);
		mix_predict(op, smp);
	endtask

	// drop valid, wait for every owed item, then let a write item finish
	task automatic wait_results();
		in_valid <= 1'b0;
		while (pending_mix.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// load the selected registers from cfg_plan once the block is idle
	task automatic apply_config(logic [2*wmtd_pkg::TAP_SLOTS-1:0] sel);
		wait_results();
		for (int i = 0; i < 2 * wmtd_pkg::TAP_SLOTS; i++) begin
			if (sel[i]) begin
				cfg_we    <= 1'b1;
				cfg_index <= wmtd_pkg::REG_IDX_W'(i);
				cfg_wdata <= cfg_plan[i];
				@(posedge clk);
				shadow_reg_write(wmtd_pkg::REG_IDX_W'(i), cfg_plan[i]);
			end
		end
		cfg_we <= 1'b0;
	endtask

	function automatic wmtd_pkg::sample_t pick_sample();
		case ($urandom_range(7))
			0:       return wmtd_pkg::sample_t'(wmtd_pkg::SAT_MAX);
			1:       return wmtd_pkg::sample_t'(wmtd_pkg::SAT_MIN);
			2:       return '0;
			default: return wmtd_pkg::sample_t'($urandom);
		endcase
	endfunction

	// mostly mixing traffic, with reads, plain stores and a few dropped codes
	function automatic wmtd_pkg::cmd_t pick_cmd();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55) return wmtd_pkg::CMD_PROCESS;
		if (r < 72) return wmtd_pkg::CMD_READ;
		if (r < 95) return wmtd_pkg::CMD_WRITE;
		return wmtd_pkg::CMD_NOP;
	endfunction

	// send n items that the block acts on; dropped codes ride along uncounted
	task automatic send_random(int n);
		wmtd_pkg::cmd_t op;
		int             sent;
		sent = 0;
		while (sent < n) begin
			op = pick_cmd();
			send_item(op, pick_sample());
			if (op != wmtd_pkg::CMD_NOP) sent++;
		end
	endtask

	// draw a fresh register set: mostly short delays so taps see recent data
	task automatic random_config();
		int unsigned d;
		for (int t = 0; t < wmtd_pkg::TAP_SLOTS; t++) begin
			case ($urandom_range(9))
				0:       d = 0;
				1:       d = wmtd_pkg::STORE_DEPTH;
				2:       d = $urandom_range((1 << wmtd_pkg::DLY_W) - 1);
				3:       d = 1;
				default: d = $urandom_range(12, 1);
			endcase
			// upper data bits above the delay field are random and must be ignored
			cfg_plan[wmtd_pkg::REG_DELAY_TAP0 + t] = wmtd_pkg::CFG_W'($urandom);
			cfg_plan[wmtd_pkg::REG_DELAY_TAP0 + t][wmtd_pkg::DLY_W-1:0] =
				wmtd_pkg::DLY_W'(d);
			case ($urandom_range(7))
				0: cfg_plan[wmtd_pkg::REG_GAIN_TAP0 + t] =
					wmtd_pkg::CFG_W'(wmtd_pkg::SAT_MAX);
				1: cfg_plan[wmtd_pkg::REG_GAIN_TAP0 + t] =
					wmtd_pkg::CFG_W'(wmtd_pkg::SAT_MIN);
				2: cfg_plan[wmtd_pkg::REG_GAIN_TAP0 + t] = '0;
				3: cfg_plan[wmtd_pkg::REG_GAIN_TAP0 + t] =
					wmtd_pkg::CFG_W'(1 << wmtd_pkg::RND_SHIFT);
				default: cfg_plan[wmtd_pkg::REG_GAIN_TAP0 + t] =
					wmtd_pkg::CFG_W'($urandom);
			endcase
		end
		apply_config('1);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// full-scale samples against full-scale weights: drive both saturation rails
	task automatic test_mix_saturation();
		for (int t = 0; t < wmtd_pkg::TAP_SLOTS; t++) begin
			cfg_plan[wmtd_pkg::REG_DELAY_TAP0 + t] =
				{{(wmtd_pkg::CFG_W - wmtd_pkg::DLY_W){1'b1}}, wmtd_pkg::DLY_W'(t + 1)};
			cfg_plan[wmtd_pkg::REG_GAIN_TAP0 + t] = wmtd_pkg::CFG_W'(wmtd_pkg::SAT_MAX);
		end
		apply_config('1);
		repeat (5) send_item(wmtd_pkg::CMD_PROCESS, wmtd_pkg::sample_t'(wmtd_pkg::SAT_MAX));
		for (int t = 0; t < wmtd_pkg::TAP_SLOTS; t++)
			cfg_plan[wmtd_pkg::REG_GAIN_TAP0 + t] = wmtd_pkg::CFG_W'(wmtd_pkg::SAT_MIN);
		apply_config('1);
		repeat (5) send_item(wmtd_pkg::CMD_PROCESS, wmtd_pkg::sample_t'(wmtd_pkg::SAT_MIN));
	endtask

	// half-step sums on both signs: round half up toward plus infinity
	task automatic test_rounding();
		cfg_plan[wmtd_pkg::REG_GAIN_TAP0] = wmtd_pkg::CFG_W'(wmtd_pkg::RND_BIAS);
		for (int t = 1; t < wmtd_pkg::TAP_SLOTS; t++)
			cfg_plan[wmtd_pkg::REG_GAIN_TAP0 + t] = '0;
		apply_config('1);
		send_item(wmtd_pkg::CMD_PROCESS, wmtd_pkg::sample_t'(1));
		send_item(wmtd_pkg::CMD_PROCESS, wmtd_pkg::sample_t'(-1));
		send_item(wmtd_pkg::CMD_PROCESS, wmtd_pkg::sample_t'(3));
		send_item(wmtd_pkg::CMD_PROCESS, wmtd_pkg::sample_t'(-3));
		send_item(wmtd_pkg::CMD_PROCESS, '0);
		send_item(wmtd_pkg::CMD_PROCESS, '0);
	endtask

	// delay zero and full store read the old sample at the write pointer;
	// delays past the store are held but leave their taps in place
	task automatic test_delay_extremes();
		cfg_plan[wmtd_pkg::REG_DELAY_TAP0]     = wmtd_pkg::CFG_W'(0);
		cfg_plan[wmtd_pkg::REG_DELAY_TAP0 + 1] = wmtd_pkg::CFG_W'(wmtd_pkg::STORE_DEPTH);
		cfg_plan[wmtd_pkg::REG_DELAY_TAP0 + 2] = wmtd_pkg::CFG_W'(wmtd_pkg::STORE_DEPTH + 1);
		cfg_plan[wmtd_pkg::REG_DELAY_TAP0 + 3] =
			wmtd_pkg::CFG_W'((1 << wmtd_pkg::DLY_W) - 1);
		for (int t = 0; t < wmtd_pkg::TAP_SLOTS; t++)
			cfg_plan[wmtd_pkg::REG_GAIN_TAP0 + t] = wmtd_pkg::CFG_W'(1 << wmtd_pkg::RND_SHIFT);
		apply_config('1);
		send_item(wmtd_pkg::CMD_PROCESS, wmtd_pkg::sample_t'(16'h1234));
		send_item(wmtd_pkg::CMD_READ, '0);
		send_item(wmtd_pkg::CMD_WRITE, wmtd_pkg::sample_t'(wmtd_pkg::SAT_MAX));
		send_item(wmtd_pkg::CMD_PROCESS, '0);
	endtask

	// plain stores give nothing, reads give raw taps with a zero mix,
	// the unused code is dropped without touching the state
	task automatic test_commands();
		send_item(wmtd_pkg::CMD_WRITE, wmtd_pkg::sample_t'(wmtd_pkg::SAT_MAX));
		send_item(wmtd_pkg::CMD_WRITE, wmtd_pkg::sample_t'(wmtd_pkg::SAT_MIN));
		send_item(wmtd_pkg::CMD_READ, wmtd_pkg::sample_t'(16'h5A5A));
		send_item(wmtd_pkg::CMD_NOP, wmtd_pkg::sample_t'(16'hA5A5));
		send_item(wmtd_pkg::CMD_READ, '0);
		send_item(wmtd_pkg::CMD_PROCESS, wmtd_pkg::sample_t'(-1));
	endtask

	// hold the output off long enough that the block stalls its input
	task automatic test_output_holdoff();
		idle_pct = 0;
		stall_pct <= 0;
		hold_on <= 1'b1;
		repeat (8) send_item(wmtd_pkg::CMD_PROCESS, pick_sample());
		wait_results();
		hold_on <= 1'b0;
	endtask

	// let the block drain completely between bursts
	task automatic test_sender_pause();
		repeat (3) begin
			send_random(12);
			wait_results();
		end
	endtask

	// long random run under one idling pattern, new registers every chunk
	task automatic test_random_phase(int unsigned src_idle, int unsigned dst_stall);
		idle_pct = src_idle;
		stall_pct <= dst_stall;
		for (int n = 0; n < PHASE_ITEMS; n += ITEMS_PER_CFG) begin
			random_config();
			send_random(ITEMS_PER_CFG);
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		shadow_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_mix_saturation();
		test_rounding();
		test_delay_extremes();
		test_commands();
		test_output_holdoff();
		test_sender_pause();
		test_random_phase(0, 0);
		test_random_phase(61, 0);
		test_random_phase(0, 61);
		test_random_phase(28, 28);

		wait_results();
		if (mismatch_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
